// ===== rtl/tlpw_pkg.sv =====
// ----------------------------------------------------------------------------
// tlpw_pkg
// types and constants shared by the two-level page walker
// ----------------------------------------------------------------------------
package tlpw_pkg;

	localparam int unsigned ADDR_W  = 32;
	localparam int unsigned BASE_W  = 20;
	localparam int unsigned MAX_RES = 3;

	localparam int unsigned BIT_PRESENT  = 0;
	localparam int unsigned BIT_ACCESSED = 5;
	localparam int unsigned BIT_DIRTY    = 6;

	// input op codes
	localparam logic OP_TRANSLATE = 1'b0;
	localparam logic OP_RESPONSE  = 1'b1;

	// configuration register indexes
	localparam logic CFG_PAGING = 1'b0;
	localparam logic CFG_BASE   = 1'b1;

	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_DONE  = 2'd2,
		KIND_FAULT = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_DIR   = 3'b010,
		PH_TABLE = 3'b100
	} phase_t;

	typedef struct packed {
		phase_t              phase;
		logic [ADDR_W-1:0]   vaddr;
		logic                write;
		logic [ADDR_W-1:0]   dir_entry;
	} walk_state_t;

	typedef struct packed {
		kind_t               kind;
		logic [ADDR_W-1:0]   address;
		logic [ADDR_W-1:0]   write_word;
		logic                last;
	} result_t;

endpackage

// ===== rtl/tlpw_step.sv =====
// ----------------------------------------------------------------------------
// tlpw_step
// one step of the walk: from the current walk state and one input word,
// forms the result list and the next walk state
// ----------------------------------------------------------------------------
module tlpw_step (
	input  logic                          paging_enable,
	input  logic [tlpw_pkg::BASE_W-1:0]   directory_base,
	input  tlpw_pkg::walk_state_t         cur,
	input  logic                          op,
	input  logic [tlpw_pkg::ADDR_W-1:0]   virt_addr,
	input  logic                          write_access,
	input  logic [tlpw_pkg::ADDR_W-1:0]   read_word,
	output tlpw_pkg::walk_state_t         nxt,
	output tlpw_pkg::result_t             res [tlpw_pkg::MAX_RES],
	output logic [1:0]                    res_cnt
);
	import tlpw_pkg::*;

	logic [ADDR_W-1:0] dir_addr_req;
	logic [ADDR_W-1:0] dir_addr_pend;
	logic [ADDR_W-1:0] tbl_addr_resp;
	logic [ADDR_W-1:0] tbl_addr_saved;
	logic [ADDR_W-1:0] phys_addr;
	logic [ADDR_W-1:0] pte_new;
	logic              need_pde_wb;
	logic              need_pte_wb;

	// entry addresses: frame bits followed by a 10-bit index of 4-byte entries
	assign dir_addr_req   = {directory_base, virt_addr[31:22], 2'b00};
	assign dir_addr_pend  = {directory_base, cur.vaddr[31:22], 2'b00};
	assign tbl_addr_resp  = {read_word[31:12], cur.vaddr[21:12], 2'b00};
	assign tbl_addr_saved = {cur.dir_entry[31:12], cur.vaddr[21:12], 2'b00};
	assign phys_addr      = {read_word[31:12], cur.vaddr[11:0]};

	assign need_pde_wb = !cur.dir_entry[BIT_ACCESSED];
	assign need_pte_wb = !read_word[BIT_ACCESSED] || (!read_word[BIT_DIRTY] && cur.write);

	always_comb begin
		pte_new = read_word;
		pte_new[BIT_ACCESSED] = 1'b1;
		if (cur.write) begin
			pte_new[BIT_DIRTY] = 1'b1;
		end
	end

	always_comb begin
		nxt     = cur;
		res_cnt = 2'd0;
		for (int i = 0; i < MAX_RES; i++) begin
			res[i] = '{kind: KIND_READ, address: '0, write_word: '0, last: 1'b0};
		end

		unique case (cur.phase)
			PH_DIR: begin
				if (op == OP_RESPONSE) begin
					res_cnt = 2'd1;
					if (!read_word[BIT_PRESENT]) begin
						nxt.phase = PH_IDLE;
						res[0] = '{kind: KIND_FAULT, address: cur.vaddr,
							write_word: '0, last: 1'b1};
					end else begin
						nxt.phase     = PH_TABLE;
						nxt.dir_entry = read_word;
						res[0] = '{kind: KIND_READ, address: tbl_addr_resp,
							write_word: '0, last: 1'b1};
					end
				end
			end
			PH_TABLE: begin
				if (op == OP_RESPONSE) begin
					nxt.phase = PH_IDLE;
					if (!read_word[BIT_PRESENT]) begin
						res_cnt = 2'd1;
						res[0] = '{kind: KIND_FAULT, address: cur.vaddr,
							write_word: '0, last: 1'b1};
					end else begin
						// write-backs first, directory entry before table entry
						if (need_pde_wb) begin
							res[res_cnt] = '{kind: KIND_WRITE, address: dir_addr_pend,
								write_word: cur.dir_entry | (ADDR_W'(1) << BIT_ACCESSED),
								last: 1'b0};
							res_cnt = res_cnt + 2'd1;
						end
						if (need_pte_wb) begin
							res[res_cnt] = '{kind: KIND_WRITE, address: tbl_addr_saved,
								write_word: pte_new, last: 1'b0};
							res_cnt = res_cnt + 2'd1;
						end
						res[res_cnt] = '{kind: KIND_DONE, address: phys_addr,
							write_word: '0, last: 1'b1};
						res_cnt = res_cnt + 2'd1;
					end
				end
			end
			default: begin
				// idle: only translate requests do anything
				if (op == OP_TRANSLATE) begin
					res_cnt = 2'd1;
					if (!paging_enable) begin
						res[0] = '{kind: KIND_DONE, address: virt_addr,
							write_word: '0, last: 1'b1};
					end else begin
						nxt.phase = PH_DIR;
						nxt.vaddr = virt_addr;
						nxt.write = write_access;
						res[0] = '{kind: KIND_READ, address: dir_addr_req,
							write_word: '0, last: 1'b1};
					end
				end
			end
		endcase
	end

endmodule

// ===== rtl/two_level_page_walker_core.sv =====
// ----------------------------------------------------------------------------
// two_level_page_walker_core
// two-level 4 KiB page table walker with accessed/dirty write-back
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tuser op, tdata vaddr/write/read word
//  m_*      out  m_tvalid/m_tready  tuser kind, tdata address/write word, tlast
//  cfg_*    in   cfg_we             cfg_index, cfg_data
//
//  an input word is registered, then worked combinationally into up to three
//  result words held in a small output shift stage; while m_tready is high,
//  one word leaves a cycle and an input is taken every cycle while each
//  causes at most one result; a walk end with write-backs holds the input side until
//  its extra words have left; arst_n clears the walk state, the output stage and both
//  registers; a stalled output holds its word; the input register still takes one word
// ----------------------------------------------------------------------------
module two_level_page_walker_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [19:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic        s_tuser,   // op
	input  logic [71:0] s_tdata,   // virt_addr[31:0], write_access[32], read_word[64:33], zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [1:0]  m_tuser,   // kind
	output logic [63:0] m_tdata,   // address[31:0], write_word[63:32]
	output logic        m_tlast
);
	import tlpw_pkg::*;

	logic                paging_enable_q;
	logic [BASE_W-1:0]   directory_base_q;
	walk_state_t         walk_q;
	walk_state_t         walk_nxt;

	logic                valid_s1;
	logic                op_s1;
	logic [ADDR_W-1:0]   vaddr_s1;
	logic                write_s1;
	logic [ADDR_W-1:0]   word_s1;

	result_t             step_res [MAX_RES];
	logic [1:0]          step_cnt;
	result_t             out_q [MAX_RES];
	logic [1:0]          cnt_q;

	logic                out_free;
	logic                advance;
	logic                out_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paging_enable_q  <= 1'b0;
			directory_base_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PAGING: paging_enable_q  <= cfg_data[0];
				CFG_BASE:   directory_base_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	tlpw_step u_step (
		.paging_enable  (paging_enable_q),
		.directory_base (directory_base_q),
		.cur            (walk_q),
		.op             (op_s1),
		.virt_addr      (vaddr_s1),
		.write_access   (write_s1),
		.read_word      (word_s1),
		.nxt            (walk_nxt),
		.res            (step_res),
		.res_cnt        (step_cnt)
	);

	assign out_take = m_tvalid && m_tready;
	// output stage empty now, or its last word leaves this cycle
	assign out_free = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_tready);
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1    <= s_tuser;
			vaddr_s1 <= s_tdata[31:0];
			write_s1 <= s_tdata[32];
			word_s1  <= s_tdata[64:33];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '{phase: PH_IDLE, vaddr: '0, write: 1'b0, dir_entry: '0};
		end else if (advance) begin
			walk_q <= walk_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (advance) begin
			cnt_q <= step_cnt;
		end else if (out_take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= step_res;
		end else if (out_take) begin
			for (int i = 0; i < MAX_RES - 1; i++) begin
				out_q[i] <= out_q[i+1];
			end
		end
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tuser  = out_q[0].kind;
	assign m_tdata  = {out_q[0].write_word, out_q[0].address};
	assign m_tlast  = out_q[0].last;

endmodule
